[rtl/midi_track_event_parser_macros.svh]
// Assertion macros shared by the RTL of the MIDI track event parser.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef MIDI_TRACK_EVENT_PARSER_MACROS_SVH
`define MIDI_TRACK_EVENT_PARSER_MACROS_SVH

// Same-cycle implication.
`define MTEP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MTEP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/mtep_pkg.sv]
// Types and constants of the MIDI track event parser.
// No dependencies; used by midi_track_event_parser and mtep_parser.
`timescale 1ns / 1ps

package mtep_pkg;

  typedef enum logic [3:0] {
    PS_NONE,
    PS_DELTA,
    PS_AFTER,
    PS_META_L,
    PS_META_D,
    PS_OFF_V,
    PS_ON_V,
    PS_KEY_V,
    PS_CTL_V,
    PS_PITCH
  } ps_t;

  // Result kinds
  localparam logic [4:0] KIND_NOTE_OFF   = 5'd0;
  localparam logic [4:0] KIND_NOTE_ON    = 5'd1;
  localparam logic [4:0] KIND_KEY_PRESS  = 5'd2;
  localparam logic [4:0] KIND_CTRL       = 5'd3;
  localparam logic [4:0] KIND_PROG       = 5'd4;
  localparam logic [4:0] KIND_CHAN_PRESS = 5'd5;
  localparam logic [4:0] KIND_PITCH      = 5'd6;
  localparam logic [4:0] KIND_UNKNOWN    = 5'd7;
  localparam logic [4:0] KIND_META_HDR   = 5'd8;
  localparam logic [4:0] KIND_META_BYTE  = 5'd9;
  localparam logic [4:0] KIND_SEQ        = 5'd10;
  localparam logic [4:0] KIND_TEMPO      = 5'd11;
  localparam logic [4:0] KIND_TIMESIG    = 5'd12;
  localparam logic [4:0] KIND_END        = 5'd13;
  localparam logic [4:0] KIND_RPN_COARSE = 5'd14;
  localparam logic [4:0] KIND_NRPN_COARSE = 5'd16;

  // Status bytes and nibbles
  localparam logic [7:0] ST_META      = 8'hFF;
  localparam logic [7:0] ST_RT_CLOCK  = 8'hF8;
  localparam logic [7:0] ST_RT_START  = 8'hFA;
  localparam logic [7:0] ST_RT_CONT   = 8'hFB;
  localparam logic [7:0] ST_RT_STOP   = 8'hFC;
  localparam logic [3:0] NIB_OFF      = 4'h8;
  localparam logic [3:0] NIB_ON       = 4'h9;
  localparam logic [3:0] NIB_KEY      = 4'hA;
  localparam logic [3:0] NIB_CTRL     = 4'hB;
  localparam logic [3:0] NIB_PROG     = 4'hC;
  localparam logic [3:0] NIB_CHAN     = 4'hD;
  localparam logic [3:0] NIB_PITCH    = 4'hE;

  // Meta types
  localparam logic [7:0] META_SEQ     = 8'h00;
  localparam logic [7:0] META_END     = 8'h2F;
  localparam logic [7:0] META_TEMPO   = 8'h51;
  localparam logic [7:0] META_TIMESIG = 8'h58;

  // Controllers
  localparam logic [7:0] CC_DATA_MSB  = 8'd6;
  localparam logic [7:0] CC_DATA_LSB  = 8'd38;
  localparam logic [7:0] CC_NRPN_LSB  = 8'd98;
  localparam logic [7:0] CC_NRPN_MSB  = 8'd99;
  localparam logic [7:0] CC_RPN_LSB   = 8'd100;
  localparam logic [7:0] CC_RPN_MSB   = 8'd101;
  localparam logic [6:0] PARAM_NULL   = 7'h7F;

  typedef struct packed {
    logic [4:0]  event_kind;
    logic [3:0]  channel;
    logic [27:0] delta_time;
    logic [13:0] key_or_param;
    logic [31:0] value;
    logic        final_byte;
    logic        last;
  } res_t;

  // Results caused by one byte: none, one (r0) or two (r0 then r1).
  typedef struct packed {
    logic any;
    logic has2;
    res_t r0;
    res_t r1;
  } step_t;

endpackage

[rtl/mtep_in_if.sv]
// Byte input channel of the MIDI track event parser.
// Standalone interface; no dependencies.
`timescale 1ns / 1ps

interface mtep_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       track_start;

  modport source (output valid, output data_byte, output track_start, input ready);
  modport sink   (input valid, input data_byte, input track_start, output ready);
endinterface

[rtl/mtep_out_if.sv]
// Result channel of the MIDI track event parser.
// Standalone interface; no dependencies.
`timescale 1ns / 1ps

interface mtep_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  event_kind;
  logic [3:0]  channel;
  logic [27:0] delta_time;
  logic [13:0] key_or_param;
  logic [31:0] value;
  logic        final_byte;
  logic        last;

  modport source (output valid, output event_kind, output channel, output delta_time,
                  output key_or_param, output value, output final_byte, output last,
                  input ready);
  modport sink   (input valid, input event_kind, input channel, input delta_time,
                  input key_or_param, input value, input final_byte, input last,
                  output ready);
endinterface

[rtl/midi_track_event_parser.sv]
// Top level of the MIDI track event parser: parser state plus a two-entry result queue.
// Depends on mtep_pkg, mtep_in_if, mtep_out_if, mtep_parser and the assertion macros.
//
//   channel  direction  payload
//   in_ch    sink       data_byte[7:0], track_start
//   out_ch   source     event_kind, channel, delta_time, key_or_param, value,
//                       final_byte, last
//
// One byte is accepted per cycle while the queue has room; its results are registered in
// the queue (older results waiting there go out first). A byte with one result sustains
// one byte per cycle while out_ch.ready is high; a byte with two results holds the output
// for both in turn, so the queue can fill and drop in_ch.ready.
// in_ch.ready depends only on the queue fill count (two entries, one per byte).
// Synchronous active-low reset clears the parse state and empties the queue.
`timescale 1ns / 1ps

`include "midi_track_event_parser_macros.svh"

module midi_track_event_parser (
  input  logic        clk,
  input  logic        rst_n,
  mtep_in_if.sink     in_ch,
  mtep_out_if.source  out_ch
);

  mtep_pkg::step_t step;
  mtep_pkg::step_t q_r [2];
  mtep_pkg::step_t cur;
  mtep_pkg::res_t  res;
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_r, rd_r, sub_r;
  logic       accept, push, pop_res, pop_entry;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign accept      = in_ch.valid && in_ch.ready;

  mtep_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (accept),
    .data_byte   (in_ch.data_byte),
    .track_start (in_ch.track_start),
    .step        (step)
  );

  assign push      = accept && step.any;
  assign cur       = q_r[rd_r];
  assign res       = sub_r ? cur.r1 : cur.r0;
  assign pop_res   = out_ch.valid && out_ch.ready;
  assign pop_entry = pop_res && (sub_r || !cur.has2);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop_entry) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && pop_entry) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      sub_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_r <= !wr_r;
      end
      if (pop_entry) begin
        rd_r <= !rd_r;
      end
      // advance to the second result of a pair, back to the first on entry pop
      if (pop_res) begin
        sub_r <= !pop_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= step;
    end
  end

  assign out_ch.valid        = (cnt_r != 2'd0);
  assign out_ch.event_kind   = res.event_kind;
  assign out_ch.channel      = res.channel;
  assign out_ch.delta_time   = res.delta_time;
  assign out_ch.key_or_param = res.key_or_param;
  assign out_ch.value        = res.value;
  assign out_ch.final_byte   = res.final_byte;
  assign out_ch.last         = res.last;

  `MTEP_ASSERT_NOW(a_cnt_range, 1'b1, cnt_r != 2'd3, "result queue count out of range")
  `MTEP_ASSERT_NOW(a_final_kind, out_ch.valid && out_ch.final_byte,
    out_ch.event_kind == mtep_pkg::KIND_META_BYTE, "final flag on non meta-byte result")
  `MTEP_ASSERT_NEXT(a_pair_follows, out_ch.valid && out_ch.ready && !out_ch.last,
    out_ch.valid, "second result of a pair missing")
  `MTEP_ASSERT_NOW(a_sub_pair, sub_r, cnt_r != 2'd0 && cur.has2,
    "second-result select without a pending pair")

endmodule

[rtl/mtep_parser.sv]
// Parse state registers and per-byte decode of the MIDI track event parser.
// Depends on mtep_pkg.
`timescale 1ns / 1ps

module mtep_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step_en,
  input  logic [7:0]      data_byte,
  input  logic            track_start,
  output mtep_pkg::step_t step
);

  mtep_pkg::ps_t state_r, state_nxt, st;
  logic [7:0]  status_r, status_nxt;
  logic [3:0]  chan_r, chan_nxt, chan_eff;
  logic [27:0] delta_r, delta_nxt, delta_eff;
  logic [7:0]  first_r, first_nxt;
  logic [7:0]  mtype_r, mtype_nxt;
  logic [7:0]  mlen_r, mlen_nxt;
  logic [7:0]  midx_r, midx_nxt, midx_inc;
  logic [7:0]  head_r [4];
  logic [7:0]  head_nxt [4];
  logic [7:0]  hw [4];
  logic [7:0]  h1, h2, h3;
  logic [6:0]  pmsb_r, pmsb_nxt;
  logic [6:0]  plsb_r, plsb_nxt;
  logic        nrpn_r, nrpn_nxt;
  logic        fin;
  mtep_pkg::res_t base;

  function automatic logic [6:0] clamp_param(input logic [7:0] v);
    clamp_param = (v >= 8'd127) ? mtep_pkg::PARAM_NULL : v[6:0];
  endfunction

  always_comb begin
    st        = track_start ? mtep_pkg::PS_NONE : state_r;
    chan_eff  = track_start ? 4'd0 : chan_r;
    delta_eff = track_start ? 28'd0 : delta_r;

    state_nxt = st;
    status_nxt = status_r;
    chan_nxt  = chan_eff;
    delta_nxt = delta_eff;
    first_nxt = first_r;
    mtype_nxt = mtype_r;
    mlen_nxt  = mlen_r;
    midx_nxt  = midx_r;
    for (int k = 0; k < 4; k++) begin
      head_nxt[k] = head_r[k];
      hw[k] = (midx_r == 8'(k)) ? data_byte : head_r[k];
    end
    pmsb_nxt  = pmsb_r;
    plsb_nxt  = plsb_r;
    nrpn_nxt  = nrpn_r;

    midx_inc = midx_r + 8'd1;
    fin      = (midx_inc == mlen_r);
    h1 = (mlen_r >= 8'd2) ? hw[1] : 8'd0;
    h2 = (mlen_r >= 8'd3) ? hw[2] : 8'd0;
    h3 = (mlen_r >= 8'd4) ? hw[3] : 8'd0;

    base = '{event_kind: mtep_pkg::KIND_NOTE_OFF, channel: chan_eff, delta_time: delta_eff,
             key_or_param: 14'd0, value: 32'd0, final_byte: 1'b0, last: 1'b1};
    step.any  = 1'b0;
    step.has2 = 1'b0;
    step.r0   = base;
    step.r1   = base;

    unique case (st) inside
      mtep_pkg::PS_NONE, mtep_pkg::PS_DELTA: begin
        delta_nxt = {((st == mtep_pkg::PS_NONE) ? 21'd0 : delta_eff[20:0]), data_byte[6:0]};
        state_nxt = data_byte[7] ? mtep_pkg::PS_DELTA : mtep_pkg::PS_AFTER;
      end
      mtep_pkg::PS_AFTER: begin
        if (data_byte[7]) begin
          status_nxt = data_byte;
          chan_nxt   = data_byte[3:0];
        end else if (status_r == mtep_pkg::ST_META) begin
          mtype_nxt = data_byte;
          state_nxt = mtep_pkg::PS_META_L;
        end else if (status_r == mtep_pkg::ST_RT_CLOCK || status_r == mtep_pkg::ST_RT_START ||
                     status_r == mtep_pkg::ST_RT_CONT || status_r == mtep_pkg::ST_RT_STOP) begin
          // drop data under realtime status
        end else begin
          case (status_r[7:4])
            mtep_pkg::NIB_OFF: begin
              first_nxt = data_byte;
              state_nxt = mtep_pkg::PS_OFF_V;
            end
            mtep_pkg::NIB_ON: begin
              first_nxt = data_byte;
              state_nxt = mtep_pkg::PS_ON_V;
            end
            mtep_pkg::NIB_KEY: begin
              first_nxt = data_byte;
              state_nxt = mtep_pkg::PS_KEY_V;
            end
            mtep_pkg::NIB_CTRL: begin
              first_nxt = data_byte;
              state_nxt = mtep_pkg::PS_CTL_V;
            end
            mtep_pkg::NIB_PITCH: begin
              first_nxt = data_byte;
              state_nxt = mtep_pkg::PS_PITCH;
            end
            mtep_pkg::NIB_PROG: begin
              step.any = 1'b1;
              step.r0.event_kind = mtep_pkg::KIND_PROG;
              step.r0.value = {24'd0, data_byte};
              state_nxt = mtep_pkg::PS_NONE;
            end
            mtep_pkg::NIB_CHAN: begin
              step.any = 1'b1;
              step.r0.event_kind = mtep_pkg::KIND_CHAN_PRESS;
              step.r0.value = {24'd0, data_byte};
              state_nxt = mtep_pkg::PS_NONE;
            end
            default: begin
              step.any = 1'b1;
              step.r0.event_kind = mtep_pkg::KIND_UNKNOWN;
              step.r0.key_or_param = {6'd0, status_r};
              step.r0.value = {24'd0, data_byte};
              state_nxt = mtep_pkg::PS_NONE;
            end
          endcase
        end
      end
      mtep_pkg::PS_META_L: begin
        mlen_nxt = data_byte;
        midx_nxt = 8'd0;
        step.any = 1'b1;
        step.r0.event_kind = mtep_pkg::KIND_META_HDR;
        step.r0.key_or_param = {6'd0, mtype_r};
        step.r0.value = {24'd0, data_byte};
        if (data_byte == 8'd0) begin
          state_nxt = mtep_pkg::PS_NONE;
          if (mtype_r == mtep_pkg::META_END) begin
            step.has2 = 1'b1;
            step.r0.last = 1'b0;
            step.r1.event_kind = mtep_pkg::KIND_END;
          end
        end else begin
          state_nxt = mtep_pkg::PS_META_D;
        end
      end
      mtep_pkg::PS_META_D: begin
        if (midx_r < 8'd4) begin
          head_nxt[midx_r[1:0]] = data_byte;
        end
        midx_nxt = midx_inc;
        step.any = 1'b1;
        step.r0.event_kind = mtep_pkg::KIND_META_BYTE;
        step.r0.key_or_param = {6'd0, mtype_r};
        step.r0.value = {24'd0, data_byte};
        step.r0.final_byte = fin;
        if (fin) begin
          state_nxt = mtep_pkg::PS_NONE;
          if (mtype_r == mtep_pkg::META_SEQ && mlen_r >= 8'd2) begin
            step.has2 = 1'b1;
            step.r1.event_kind = mtep_pkg::KIND_SEQ;
            step.r1.value = {16'd0, hw[0], h1};
          end else if (mtype_r == mtep_pkg::META_TEMPO && mlen_r >= 8'd3) begin
            step.has2 = 1'b1;
            step.r1.event_kind = mtep_pkg::KIND_TEMPO;
            step.r1.value = {8'd0, hw[0], h1, h2};
          end else if (mtype_r == mtep_pkg::META_TIMESIG) begin
            step.has2 = 1'b1;
            step.r1.event_kind = mtep_pkg::KIND_TIMESIG;
            step.r1.value = {hw[0], h1, h2, h3};
          end
          step.r0.last = !step.has2;
        end
      end
      mtep_pkg::PS_OFF_V, mtep_pkg::PS_ON_V, mtep_pkg::PS_KEY_V: begin
        step.any = 1'b1;
        step.r0.event_kind = (st == mtep_pkg::PS_OFF_V) ? mtep_pkg::KIND_NOTE_OFF :
                             (st == mtep_pkg::PS_ON_V)  ? mtep_pkg::KIND_NOTE_ON :
                                                          mtep_pkg::KIND_KEY_PRESS;
        step.r0.key_or_param = {6'd0, first_r};
        step.r0.value = {24'd0, data_byte};
        state_nxt = mtep_pkg::PS_NONE;
      end
      mtep_pkg::PS_CTL_V: begin
        step.any = 1'b1;
        step.r0.event_kind = mtep_pkg::KIND_CTRL;
        step.r0.key_or_param = {6'd0, first_r};
        step.r0.value = {24'd0, data_byte};
        state_nxt = mtep_pkg::PS_NONE;
        case (first_r) inside
          mtep_pkg::CC_NRPN_LSB: begin
            plsb_nxt = clamp_param(data_byte);
            nrpn_nxt = 1'b1;
          end
          mtep_pkg::CC_NRPN_MSB: begin
            pmsb_nxt = clamp_param(data_byte);
            nrpn_nxt = 1'b1;
          end
          mtep_pkg::CC_RPN_LSB: begin
            plsb_nxt = clamp_param(data_byte);
            nrpn_nxt = 1'b0;
          end
          mtep_pkg::CC_RPN_MSB: begin
            pmsb_nxt = clamp_param(data_byte);
            nrpn_nxt = 1'b0;
          end
          mtep_pkg::CC_DATA_MSB, mtep_pkg::CC_DATA_LSB: begin
            // report data entry only for a selected (non-null) parameter
            if (plsb_r != mtep_pkg::PARAM_NULL && pmsb_r != mtep_pkg::PARAM_NULL) begin
              step.has2 = 1'b1;
              step.r0.last = 1'b0;
              step.r1.event_kind = (nrpn_r ? mtep_pkg::KIND_NRPN_COARSE
                                           : mtep_pkg::KIND_RPN_COARSE)
                                   + {4'd0, first_r == mtep_pkg::CC_DATA_LSB};
              step.r1.key_or_param = {pmsb_r, plsb_r};
              step.r1.value = {24'd0, data_byte};
            end
          end
          default: begin
          end
        endcase
      end
      mtep_pkg::PS_PITCH: begin
        step.any = 1'b1;
        step.r0.event_kind = mtep_pkg::KIND_PITCH;
        step.r0.key_or_param = {6'd0, first_r};
        step.r0.value = {17'd0, data_byte, 7'd0} | {24'd0, first_r};
        state_nxt = mtep_pkg::PS_NONE;
      end
      default: begin
        state_nxt = mtep_pkg::PS_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= mtep_pkg::PS_NONE;
      status_r <= 8'd0;
      chan_r   <= 4'd0;
      delta_r  <= 28'd0;
      first_r  <= 8'd0;
      mtype_r  <= 8'd0;
      mlen_r   <= 8'd0;
      midx_r   <= 8'd0;
      for (int k = 0; k < 4; k++) begin
        head_r[k] <= 8'd0;
      end
      pmsb_r   <= mtep_pkg::PARAM_NULL;
      plsb_r   <= mtep_pkg::PARAM_NULL;
      nrpn_r   <= 1'b0;
    end else if (step_en) begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
      chan_r   <= chan_nxt;
      delta_r  <= delta_nxt;
      first_r  <= first_nxt;
      mtype_r  <= mtype_nxt;
      mlen_r   <= mlen_nxt;
      midx_r   <= midx_nxt;
      for (int k = 0; k < 4; k++) begin
        head_r[k] <= head_nxt[k];
      end
      pmsb_r   <= pmsb_nxt;
      plsb_r   <= plsb_nxt;
      nrpn_r   <= nrpn_nxt;
    end
  end

endmodule
